/* rtl/pse_pkg.sv */
// Shared types, constants and a color helper for the palette pixel span expander.
package pse_pkg;

    localparam int MAX_SPAN  = 1024;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int COLOR_W   = 24;
    localparam int PIX_W     = 16;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 8;

    typedef enum logic [1:0] {
        CMD_PAL_WRITE  = 2'd0,
        CMD_SPAN_START = 2'd1,
        CMD_DATA       = 2'd2,
        CMD_RSVD       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DEPTH_1    = 2'd0,
        DEPTH_4    = 2'd1,
        DEPTH_8    = 2'd2,
        DEPTH_NONE = 2'd3
    } t_depth;

    // One palette lookup on its way to the color stage
    typedef struct packed {
        logic valid;
        logic raw;
        logic last;
    } t_rd_req;

    function automatic logic [PIX_W-1:0] to_565(input logic [COLOR_W-1:0] c);
        to_565 = {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

/* rtl/pse_if.sv */
// Handshake channel interfaces: command items in, pixel items out.
interface pse_in_if;
    import pse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [IDX_W-1:0]     palette_index;
    logic [COLOR_W-1:0]   palette_color;
    logic [1:0]           depth_code;
    logic [2:0]           start_offset;
    logic [CNT_W-1:0]     pixel_count;
    logic [7:0]           data_byte;

    modport source (output valid, cmd, palette_index, palette_color, depth_code,
                    start_offset, pixel_count, data_byte, input ready);
    modport sink   (input valid, cmd, palette_index, palette_color, depth_code,
                    start_offset, pixel_count, data_byte, output ready);
endinterface

interface pse_out_if;
    import pse_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_color;
    logic             last_pixel;

    modport source (output valid, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_color, last_pixel, output ready);
endinterface

/* rtl/pse_ram.sv */
// Generic single-write, single-read RAM with registered read-first output.
module pse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pse_span_ctrl.sv */
// Span state and pixel unpacker: takes items, issues one palette read per pixel.
module pse_span_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pse_in_if.sink                i_item,
    input  logic                  i_advance,
    output pse_pkg::t_rd_req      o_req,
    output logic [pse_pkg::PAL_AW-1:0]  o_raddr,
    output logic                  o_we,
    output logic [pse_pkg::PAL_AW-1:0]  o_waddr,
    output logic [pse_pkg::COLOR_W-1:0] o_wdata
);
    import pse_pkg::*;

    logic             r_busy, n_busy;
    logic [7:0]       r_byte, n_byte;
    logic [2:0]       r_pos, n_pos;
    logic [CNT_W-1:0] r_remaining, n_remaining;
    logic [2:0]       r_bit_pos, n_bit_pos;
    logic [1:0]       r_depth, n_depth;
    logic             r_first, n_first;

    logic             fire, done, byte_end, last_pix, accept;
    logic [CNT_W-1:0] rem_after, sat_cnt;
    logic [2:0]       first_pos;

    // Pixel selection out of the held byte, MSB first
    always_comb begin
        case (r_depth)
            DEPTH_1: begin
                o_raddr  = PAL_AW'(r_byte[3'd7 - r_pos]);
                byte_end = (r_pos == 3'd7);
            end
            DEPTH_4: begin
                o_raddr  = r_pos[0] ? PAL_AW'(r_byte[3:0]) : PAL_AW'(r_byte[7:4]);
                byte_end = r_pos[0];
            end
            default: begin
                o_raddr  = PAL_AW'(r_byte);
                byte_end = 1'b1;
            end
        endcase
    end

    always_comb begin
        last_pix  = (r_remaining == CNT_W'(1));
        fire      = r_busy && i_advance;
        done      = fire && (byte_end || last_pix);
        rem_after = fire ? r_remaining - CNT_W'(1) : r_remaining;
        accept    = i_item.valid && i_item.ready;
        sat_cnt   = (32'(i_item.pixel_count) > MAX_SPAN) ? CNT_W'(MAX_SPAN)
                                                        : i_item.pixel_count;
        case (r_depth)
            DEPTH_1: first_pos = r_bit_pos;
            DEPTH_4: first_pos = {2'b00, r_bit_pos[0]};
            default: first_pos = 3'd0;
        endcase
    end

    assign i_item.ready = !r_busy || done;
    assign o_req        = '{valid: fire, raw: (r_depth == DEPTH_1), last: last_pix};
    assign o_we         = accept && (i_item.cmd == CMD_PAL_WRITE);
    assign o_waddr      = PAL_AW'(i_item.palette_index);
    assign o_wdata      = i_item.palette_color;

    always_comb begin
        n_busy      = r_busy && !done;
        n_byte      = r_byte;
        n_pos       = fire ? r_pos + 3'd1 : r_pos;
        n_remaining = rem_after;
        n_bit_pos   = r_bit_pos;
        n_depth     = r_depth;
        n_first     = r_first;
        if (accept) begin
            case (i_item.cmd)
                CMD_SPAN_START: begin
                    n_depth     = i_item.depth_code;
                    n_bit_pos   = i_item.start_offset;
                    n_remaining = (i_item.depth_code == DEPTH_NONE) ? '0 : sat_cnt;
                    n_first     = 1'b1;
                end
                CMD_DATA: begin
                    // a byte after the span ran out yields nothing
                    if (rem_after != '0) begin
                        n_busy    = 1'b1;
                        n_byte    = i_item.data_byte;
                        n_pos     = r_first ? first_pos : 3'd0;
                        n_first   = 1'b0;
                        n_bit_pos = 3'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_remaining <= '0;
            r_bit_pos   <= '0;
            r_depth     <= DEPTH_1;
            r_first     <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_remaining <= n_remaining;
            r_bit_pos   <= n_bit_pos;
            r_depth     <= n_depth;
            r_first     <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_pos  <= n_pos;
    end

endmodule

/* rtl/pse_color.sv */
// Color stage: takes palette read data, converts to 5-6-5 (1 bpp: low 16 bits as read) and holds the output item.
module pse_color (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pse_pkg::t_rd_req            i_req,
    input  logic [pse_pkg::COLOR_W-1:0] i_rdata,
    output logic                        o_advance,
    pse_out_if.source                   o_pixel
);
    import pse_pkg::*;

    logic             r_b_valid;
    logic             r_b_raw;
    logic             r_b_last;
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_color;
    logic             r_o_last;

    // Whole pipe moves when the output register is free or being taken
    assign o_advance = !r_o_valid || o_pixel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (o_advance) begin
            r_b_valid <= i_req.valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_b_raw   <= i_req.raw;
            r_b_last  <= i_req.last;
            r_o_color <= r_b_raw ? i_rdata[PIX_W-1:0] : to_565(i_rdata);
            r_o_last  <= r_b_last;
        end
    end

    assign o_pixel.valid       = r_o_valid;
    assign o_pixel.pixel_color = r_o_color;
    assign o_pixel.last_pixel  = r_o_last;

endmodule

/* rtl/palette_pixel_span_expander_core.sv */
// Top level of the palette pixel span expander.
//
//  channel  dir  handshake      payload
//  i_item   in   valid/ready    cmd, palette_index, palette_color, depth_code,
//                               start_offset, pixel_count, data_byte
//  o_pixel  out  valid/ready    pixel_color, last_pixel
//
// One pixel leaves per cycle while o_pixel is not stalled; a data byte gives up to
// 8, 2 or 1 pixels at 1, 4 and 8 bpp, one lookup each on the single palette RAM read port.
// Palette writes and span starts issue no lookup; the next item is taken in the
// cycle that issues the last lookup of the current byte.
// After a byte is taken, its first pixel goes through the held byte register, the
// palette RAM read register and the color register before it is valid.
// A stall on o_pixel freezes the whole lookup pipe. Reset is synchronous, active
// low, and needs no clearing pass.
module palette_pixel_span_expander_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_in_if.sink    i_item,
    pse_out_if.source o_pixel
);
    import pse_pkg::*;

    t_rd_req             req;
    logic                advance;
    logic [PAL_AW-1:0]   raddr;
    logic                we;
    logic [PAL_AW-1:0]   waddr;
    logic [COLOR_W-1:0]  wdata;
    logic [COLOR_W-1:0]  rdata;

    pse_span_ctrl u_span_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_req     (req),
        .o_raddr   (raddr),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    pse_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (advance),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pse_color u_color (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rdata   (rdata),
        .o_advance (advance),
        .o_pixel   (o_pixel)
    );

endmodule

/* rtl/pse_checker.sv */
// Port-level checks for the span expander, bound to the top level.
module pse_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [pse_pkg::PIX_W-1:0] i_out_color,
    input logic                     i_out_last
);
    import pse_pkg::*;

    // Reset empties the pipe: nothing shown, input open
    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_color) && $stable(i_out_last))
        else $error("output item changed while stalled");

endmodule

bind palette_pixel_span_expander_core pse_checker u_pse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_pixel.valid),
    .i_out_ready (o_pixel.ready),
    .i_out_color (o_pixel.pixel_color),
    .i_out_last  (o_pixel.last_pixel)
);

/* tb/sv/palette_pixel_span_expander_core_tb.sv */
// Self-checking testbench for the palette pixel span expander core.
`timescale 1ns / 100ps

module palette_pixel_span_expander_core_tb;
    import pse_pkg::*;

    localparam int PHASE_ITEMS  = 100;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [IDX_W-1:0]   pal_idx;
        logic [COLOR_W-1:0] pal_color;
        logic [1:0]         depth;
        logic [2:0]         offset;
        logic [CNT_W-1:0]   count;
        logic [7:0]         data;
    } t_cmd_item;

    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic             last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pse_in_if  in_ch();
    pse_out_if out_ch();

    palette_pixel_span_expander_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_pixel (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus side
    t_cmd_item pending_q[$];
    t_cmd_item drv_item;
    logic      gen_written [PAL_DEPTH];
    logic [1:0] gen_depth;
    int        n_pushed;
    int        src_idle_pct;
    int        snk_stall_pct;

    // Predicted block state
    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    logic [CNT_W-1:0]   sp_left;
    logic [2:0]         sp_pos;
    logic [1:0]         sp_depth;
    logic               sp_first;
    t_pixel             exp_pixels_q[$];

    // Scoreboard
    t_pixel got_pix;
    t_pixel want_pix;
    int     n_accepted;
    int     n_spans;
    int     n_pixels;
    int     n_errors;
    int     cycles;

    function automatic logic [PIX_W-1:0] rgb_to_565(input logic [COLOR_W-1:0] c);
        logic [COLOR_W-1:0] t;
        t = ((c & 24'hF80000) >> 8) | ((c & 24'h00FC00) >> 5) | ((c & 24'h0000F8) >> 3);
        return t[PIX_W-1:0];
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] color);
        t_pixel p;
        sp_left  = sp_left - 1'b1;
        p.color  = color;
        p.last   = (sp_left == '0);
        exp_pixels_q.push_back(p);
    endtask

    // Updates the predicted state for one accepted item and queues its pixels
    task automatic expand_item(input t_cmd_item it);
        int pos;
        int cnt;
        case (it.cmd)
            CMD_PAL_WRITE: pal_mem[it.pal_idx] = it.pal_color;
            CMD_SPAN_START: begin
                cnt = int'(it.count);
                if (cnt > MAX_SPAN)
                    cnt = MAX_SPAN;
                sp_depth = it.depth;
                sp_pos   = it.offset;
                sp_left  = (it.depth == DEPTH_NONE) ? '0 : cnt[CNT_W-1:0];
                sp_first = 1'b1;
                n_spans++;
            end
            CMD_DATA: begin
                if (sp_left != '0) begin
                    pos      = sp_first ? sp_pos : 0;
                    sp_first = 1'b0;
                    sp_pos   = '0;
                    case (sp_depth)
                        DEPTH_1: begin
                            // 1 bpp entries carry a ready-made 16-bit color
                            while (pos < 8 && sp_left != '0) begin
                                push_pixel(pal_mem[it.data[7-pos]][PIX_W-1:0]);
                                pos++;
                            end
                        end
                        DEPTH_4: begin
                            pos = pos & 1;
                            while (pos < 2 && sp_left != '0) begin
                                push_pixel(rgb_to_565(pal_mem[pos ? it.data[3:0]
                                                                  : it.data[7:4]]));
                                pos++;
                            end
                        end
                        DEPTH_8: push_pixel(rgb_to_565(pal_mem[it.data]));
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_cmd_item rand_item();
        t_cmd_item it;
        it.cmd       = 2'($urandom_range(0, 3));
        it.pal_idx   = IDX_W'($urandom_range(0, 255));
        it.pal_color = COLOR_W'($urandom);
        it.depth     = 2'($urandom_range(0, 3));
        it.offset    = 3'($urandom_range(0, 7));
        it.count     = CNT_W'($urandom_range(0, 2047));
        it.data      = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic add_item(input t_cmd_item it);
        pending_q.push_back(it);
        n_pushed++;
    endtask

    task automatic add_write(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] color);
        t_cmd_item it;
        it           = rand_item();
        it.cmd       = CMD_PAL_WRITE;
        it.pal_idx   = idx;
        it.pal_color = color;
        gen_written[idx] = 1'b1;
        add_item(it);
    endtask

    task automatic add_span(input logic [1:0] d, input logic [2:0] off,
                            input logic [CNT_W-1:0] cnt);
        t_cmd_item it;
        it        = rand_item();
        it.cmd    = CMD_SPAN_START;
        it.depth  = d;
        it.offset = off;
        it.count  = cnt;
        gen_depth = d;
        add_item(it);
    endtask

    task automatic fill_entry(input logic [IDX_W-1:0] idx);
        if (!gen_written[idx])
            add_write(idx, COLOR_W'($urandom));
    endtask

    // A byte may only look up entries that hold a color already
    task automatic add_data(input logic [7:0] b);
        t_cmd_item it;
        case (gen_depth)
            DEPTH_1: begin
                fill_entry(8'd0);
                fill_entry(8'd1);
            end
            DEPTH_4: begin
                fill_entry({4'd0, b[7:4]});
                fill_entry({4'd0, b[3:0]});
            end
            DEPTH_8: fill_entry(b);
            default: ;
        endcase
        it      = rand_item();
        it.cmd  = CMD_DATA;
        it.data = b;
        add_item(it);
    endtask

    task automatic add_noise();
        t_cmd_item it;
        it     = rand_item();
        it.cmd = CMD_RSVD;
        add_item(it);
    endtask

    // One span start followed mostly by exactly the bytes it needs
    task automatic gen_span_seq();
        logic [1:0] d;
        int off;
        int cnt;
        int left;
        int per;
        int need;
        int nb;
        int r;
        int k;
        logic first;
        r = $urandom_range(0, 9);
        d = (r < 3) ? DEPTH_1 : (r < 6) ? DEPTH_4 : (r < 9) ? DEPTH_8 : DEPTH_NONE;
        off = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        if (r < 5)
            cnt = 0;
        else if (r < 85)
            cnt = $urandom_range(1, 24);
        else if (r < 93)
            cnt = $urandom_range(25, 200);
        else
            cnt = $urandom_range(1000, 2047);
        add_span(d, 3'(off), CNT_W'(cnt));

        left  = (cnt > MAX_SPAN) ? MAX_SPAN : cnt;
        if (d == DEPTH_NONE)
            left = 0;
        need  = 0;
        first = 1'b1;
        while (left > 0) begin
            if (d == DEPTH_1)
                per = 8 - (first ? off : 0);
            else if (d == DEPTH_4)
                per = 2 - (first ? (off & 1) : 0);
            else
                per = 1;
            left  = left - ((per < left) ? per : left);
            first = 1'b0;
            need++;
        end
        if (d == DEPTH_NONE)
            need = $urandom_range(1, 3);

        r = $urandom_range(0, 99);
        if (need > 24)
            nb = $urandom_range(2, 10);     // long span, abandoned by the next start
        else if (r < 80)
            nb = need;
        else if (r < 90)
            nb = need + $urandom_range(1, 2);
        else
            nb = (need == 0) ? 0 : $urandom_range(0, need - 1);

        for (k = 0; k < nb; k++) begin
            if ($urandom_range(0, 99) < 6)
                add_write(IDX_W'($urandom_range(0, 255)), COLOR_W'($urandom));
            add_data(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic gen_random(input int n_items);
        int target;
        int r;
        target = n_pushed + n_items;
        while (n_pushed < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                gen_span_seq();
            else if (r < 82)
                add_write(IDX_W'($urandom_range(0, 255)), COLOR_W'($urandom));
            else if (r < 92)
                add_data(8'($urandom_range(0, 255)));
            else
                add_noise();
        end
    endtask

    task automatic gen_directed();
        add_write(8'd0, 24'h5AC3E1);
        add_write(8'd1, 24'hFFFFFF);
        add_write(8'd255, 24'hFFFFFF);
        add_write(8'd15, 24'h000000);
        add_data(8'hFF);                    // no span yet
        add_span(DEPTH_1, 3'd0, 11'd8);
        add_data(8'hA5);
        add_span(DEPTH_1, 3'd7, 11'd3);     // last bit of first byte, leftovers dropped
        add_data(8'h01);
        add_data(8'hFF);
        add_data(8'h00);                    // span already done
        add_span(DEPTH_4, 3'd1, 11'd3);
        add_data(8'hF0);
        add_data(8'h0F);
        add_span(DEPTH_8, 3'd5, 11'd2047);  // saturating count, then abandoned
        add_data(8'hFF);
        add_data(8'h00);
        add_span(DEPTH_NONE, 3'd0, 11'd5);
        add_data(8'hFF);
        add_noise();
        add_span(DEPTH_1, 3'd0, 11'd0);
        add_data(8'h55);
        add_span(DEPTH_8, 3'd0, 11'd2);
        add_data(8'hFF);
        add_write(8'd255, 24'h000000);      // recolor in the middle of a span
        add_data(8'hFF);
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expand_item(drv_item);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    drv_item              = pending_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.cmd            <= drv_item.cmd;
                    in_ch.palette_index  <= drv_item.pal_idx;
                    in_ch.palette_color  <= drv_item.pal_color;
                    in_ch.depth_code     <= drv_item.depth;
                    in_ch.start_offset   <= drv_item.offset;
                    in_ch.pixel_count    <= drv_item.count;
                    in_ch.data_byte      <= drv_item.data;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Pixel checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_pix.color = out_ch.pixel_color;
            got_pix.last  = out_ch.last_pixel;
            if (exp_pixels_q.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual color %h last %b",
                         $time, got_pix.color, got_pix.last);
                n_errors++;
            end else begin
                want_pix = exp_pixels_q.pop_front();
                n_pixels++;
                if (got_pix.color !== want_pix.color || got_pix.last !== want_pix.last) begin
                    $display("%0t: pixel mismatch: expected color %h last %b, actual color %h last %b",
                             $time, want_pix.color, want_pix.last, got_pix.color, got_pix.last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d pixels still expected",
                     cycles, exp_pixels_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.cmd           = '0;
        in_ch.palette_index = '0;
        in_ch.palette_color = '0;
        in_ch.depth_code    = '0;
        in_ch.start_offset  = '0;
        in_ch.pixel_count   = '0;
        in_ch.data_byte     = '0;
        out_ch.ready        = 1'b0;
        for (int i = 0; i < PAL_DEPTH; i++) begin
            gen_written[i] = 1'b0;
            pal_mem[i]     = '0;
        end
        gen_depth     = DEPTH_1;
        sp_left       = '0;
        sp_pos        = '0;
        sp_depth      = DEPTH_1;
        sp_first      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        n_pushed      = 0;
        n_accepted    = 0;
        n_spans       = 0;
        n_pixels      = 0;
        n_errors      = 0;
        cycles        = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idling phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 69 : (ph == 3) ? 14 : 0;
            snk_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 14 : 0;
            if (ph == 0)
                gen_directed();
            gen_random(PHASE_ITEMS);
            while (pending_q.size() != 0)
                @(posedge i_clk);
        end

        while (n_accepted != n_pushed)
            @(posedge i_clk);
        while (exp_pixels_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (%0d span starts) and %0d checked pixels",
                 n_accepted, n_spans, n_pixels);
        $display("over four idling phases, %0d mismatches", n_errors);
        if (n_errors == 0 && exp_pixels_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
